// ===== rtl/core/iimg_pkg.sv =====
// ----------------------------------------------------------------------------
// iimg_pkg
// Shared sizes, widths and register codes of the integral image unit.
// ----------------------------------------------------------------------------
`default_nettype none

package iimg_pkg;

    // Largest frame the line store and position counters can hold.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam int PIX_W      = 8;
    localparam int ROWSUM_W   = 19;
    localparam int AREA_W     = 30;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 1;

    typedef logic [COL_W-1:0]    t_col;
    typedef logic [ROW_W-1:0]    t_row;
    typedef logic [ROWSUM_W-1:0] t_rowsum;
    typedef logic [AREA_W-1:0]   t_area;
    typedef logic [CFG_W-1:0]    t_cfg;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

endpackage

`default_nettype wire

// ===== rtl/core/iimg_line_store.sv =====
// ----------------------------------------------------------------------------
// iimg_line_store
// Line store of the previous row's integrals, registered read,
// with forwarding of a write that lands on the entry being read.
// ----------------------------------------------------------------------------
`default_nettype none

module iimg_line_store (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_rd_en,
    input  iimg_pkg::t_col       i_rd_addr,
    input  wire                  i_wr_en,
    input  iimg_pkg::t_col       i_wr_addr,
    input  iimg_pkg::t_area      i_wr_data,
    output iimg_pkg::t_area      o_rd_data
);

    iimg_pkg::t_area r_mem [iimg_pkg::MAX_WIDTH];
    iimg_pkg::t_area r_q;
    iimg_pkg::t_area r_fwd_data;
    logic            r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // A read and a write to the same entry in one cycle return the old data
    // from the array, so the value being written is kept and used instead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

`default_nettype wire

// ===== rtl/core/integral_image_u8_unit.sv =====
// ----------------------------------------------------------------------------
// integral_image_u8_unit
// Streaming summed-area table for 8-bit grey pixels in raster order.
// ----------------------------------------------------------------------------
// A result beat is registered in stage 1 (line store read), then in the output
// stage before it is presented; a stalled output holds it in stage 1.
// Throughput: one pixel per cycle unless the output stalls; the line store takes
// one read and one write per cycle on separate ports, with same-entry forwarding.
// Reset clears positions, the row sum and all valid flags, and sets width and
// height to 2048. The line store is not cleared: row 0 ignores what it reads.
`default_nettype none

module integral_image_u8_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Configuration write channel.
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [iimg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [iimg_pkg::CFG_W-1:0]        i_cfg_data,
    // Pixel input stream.
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire [iimg_pkg::S_TDATA_W-1:0]    i_s_tdata,  // [7:0] pixel
    // Result output stream.
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [iimg_pkg::M_TDATA_W-1:0]   o_m_tdata,  // [29:0] area_sum, rest zero
    output logic                             o_m_tlast,  // row_end
    output logic [iimg_pkg::M_TUSER_W-1:0]   o_m_tuser   // [0] frame_end
);

    iimg_pkg::t_cfg    r_img_w;
    iimg_pkg::t_cfg    r_img_h;
    iimg_pkg::t_col    r_col;
    iimg_pkg::t_row    r_row;
    iimg_pkg::t_rowsum r_rowsum;

    logic              r_s1_valid;
    iimg_pkg::t_col    r_s1_col;
    iimg_pkg::t_rowsum r_s1_rowsum;
    logic              r_s1_first;
    logic              r_s1_row_end;
    logic              r_s1_frame_end;

    logic              r_out_valid;
    iimg_pkg::t_area   r_out_sum;
    logic              r_out_row_end;
    logic              r_out_frame_end;

    iimg_pkg::t_col    n_col;
    iimg_pkg::t_row    n_row;
    iimg_pkg::t_rowsum n_rowsum;
    iimg_pkg::t_rowsum acc_rowsum;
    iimg_pkg::t_col    last_col;
    iimg_pkg::t_row    last_row;
    iimg_pkg::t_area   above;
    iimg_pkg::t_area   s1_sum;
    logic              row_end;
    logic              frame_end;
    logic              in_beat;
    logic              s1_adv;

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= iimg_pkg::CFG_W'(2048);
            r_img_h <= iimg_pkg::CFG_W'(2048);
        end else if (i_cfg_valid) begin
            unique case (iimg_pkg::t_cfg_reg'(i_cfg_index))
                iimg_pkg::REG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                iimg_pkg::REG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A size of zero acts as one and an oversize value as the maximum.
    always_comb begin
        if (r_img_w == '0) begin
            last_col = '0;
        end else if (int'(r_img_w) > iimg_pkg::MAX_WIDTH) begin
            last_col = iimg_pkg::COL_W'(iimg_pkg::MAX_WIDTH - 1);
        end else begin
            last_col = iimg_pkg::COL_W'(r_img_w - 1'b1);
        end
        if (r_img_h == '0) begin
            last_row = '0;
        end else if (int'(r_img_h) > iimg_pkg::MAX_HEIGHT) begin
            last_row = iimg_pkg::ROW_W'(iimg_pkg::MAX_HEIGHT - 1);
        end else begin
            last_row = iimg_pkg::ROW_W'(r_img_h - 1'b1);
        end
    end

    // -------------------------------------------------------------- handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign in_beat    = i_s_tvalid && o_s_tready;

    // ------------------------------------------------ position and row sum
    assign acc_rowsum = r_rowsum + iimg_pkg::ROWSUM_W'(i_s_tdata[iimg_pkg::PIX_W-1:0]);
    assign row_end    = (r_col >= last_col);
    assign frame_end  = row_end && (r_row >= last_row);

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_rowsum = r_rowsum;
        if (in_beat) begin
            if (row_end) begin
                n_col    = '0;
                n_rowsum = '0;
                n_row    = frame_end ? '0 : r_row + 1'b1;
            end else begin
                n_col    = r_col + 1'b1;
                n_rowsum = acc_rowsum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_rowsum <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_rowsum <= n_rowsum;
        end
    end

    // ---------------------------------------------- stage 1: line store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_beat) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_col       <= r_col;
            r_s1_rowsum    <= acc_rowsum;
            r_s1_first     <= (r_row == '0);
            r_s1_row_end   <= row_end;
            r_s1_frame_end <= frame_end;
        end
    end

    iimg_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_beat),
        .i_rd_addr (r_col),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (s1_sum),
        .o_rd_data (above)
    );

    assign s1_sum = (r_s1_first ? '0 : above) + iimg_pkg::AREA_W'(r_s1_rowsum);

    // --------------------------------------------------------- output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_sum       <= s1_sum;
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = iimg_pkg::M_TDATA_W'(r_out_sum);
    assign o_m_tlast  = r_out_row_end;
    assign o_m_tuser  = iimg_pkg::M_TUSER_W'(r_out_frame_end);

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for integral_image_u8_unit. A summed-area predictor
// follows every accepted pixel beat and queues the expected result beat,
// including row and frame end flags. The run walks through small, zero,
// largest and oversized frame sizes, changes sizes between phases while a
// frame is still open, and throttles both streams at several rates.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import iimg_pkg::*;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        t_area area_sum;
        logic  row_end;
        logic  frame_end;
    } area_result_t;

    typedef enum int {PIX_ANY, PIX_BRIGHT, PIX_DARK, PIX_EDGES} pix_style_e;

    localparam int RANDOM_PIXELS = 1000;

    // Predicts the integral image and checks result beats in order.
    class area_scoreboard;
        t_area        line_store[MAX_WIDTH];
        t_rowsum      row_sum;
        int unsigned  col_pos;
        int unsigned  row_pos;
        t_cfg         width_reg;
        t_cfg         height_reg;
        // Line store entries 0 .. fill-1 have been written since reset.
        int unsigned  fill;
        area_result_t pending_results[$];
        bit           failed;

        function new();
            row_sum    = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = t_cfg'(2048);
            height_reg = t_cfg'(2048);
            fill       = 0;
            failed     = 1'b0;
        endfunction

        function int unsigned effective(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void set_reg(t_cfg_reg idx, t_cfg val);
            if (idx == REG_IMAGE_WIDTH) width_reg = val;
            else height_reg = val;
        endfunction

        function void accumulate_pixel(pixel_t px);
            int unsigned  w;
            int unsigned  h;
            int unsigned  c;
            t_area        above;
            area_result_t r;
            w = effective(width_reg, MAX_WIDTH);
            h = effective(height_reg, MAX_HEIGHT);
            c = col_pos;
            if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
            row_sum = row_sum + t_rowsum'(px);
            above = (row_pos == 0) ? '0 : line_store[c];
            r.area_sum = above + t_area'(row_sum);
            line_store[c] = r.area_sum;
            if (c + 1 > fill) fill = c + 1;
            r.row_end   = (c >= w - 1);
            r.frame_end = r.row_end && (row_pos >= h - 1);
            if (r.row_end) begin
                col_pos = 0;
                row_sum = '0;
                row_pos = r.frame_end ? 0 : row_pos + 1;
            end else begin
                col_pos = c + 1;
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tlast,
                                   logic [M_TUSER_W-1:0] tuser);
            area_result_t want;
            if (pending_results.size() == 0) begin
                $error("result beat with no pixel pending: tdata=0x%08h", tdata);
                failed = 1'b1;
                return;
            end
            want = pending_results.pop_front();
            if (tdata[AREA_W-1:0] !== want.area_sum) begin
                $error("area_sum: expected %0d, got %0d", want.area_sum, tdata[AREA_W-1:0]);
                failed = 1'b1;
            end
            if (tdata[M_TDATA_W-1:AREA_W] !== '0) begin
                $error("tdata padding: expected 0, got %0h", tdata[M_TDATA_W-1:AREA_W]);
                failed = 1'b1;
            end
            if (tlast !== want.row_end) begin
                $error("row_end: expected %0b, got %0b", want.row_end, tlast);
                failed = 1'b1;
            end
            if (tuser[0] !== want.frame_end) begin
                $error("frame_end: expected %0b, got %0b", want.frame_end, tuser[0]);
                failed = 1'b1;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata = '0;   // [7:0] pixel
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;        // [29:0] area_sum, rest zero
    logic                   o_m_tlast;        // row_end
    logic [M_TUSER_W-1:0]   o_m_tuser;        // [0] frame_end

    area_scoreboard sb = new();
    int unsigned    src_idle_pct = 0;
    int unsigned    sink_stall_pct = 0;
    int unsigned    pixels_sent = 0;

    integral_image_u8_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side: check each accepted beat and pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata, o_m_tlast, o_m_tuser);
        end
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic pixel_t pick_pixel(pix_style_e style);
        case (style)
            PIX_BRIGHT: return pixel_t'(255 - $urandom_range(3));
            PIX_DARK:   return pixel_t'($urandom_range(3));
            PIX_EDGES:  return $urandom_range(1) ? pixel_t'(255) : pixel_t'(0);
            default:    return pixel_t'($urandom_range(255));
        endcase
    endfunction

    task automatic write_reg(t_cfg_reg idx, t_cfg val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Leaves tvalid high after the beat so back-to-back pixels need no gap.
    task automatic send_pixel(pixel_t px);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        do @(posedge i_clk); while (!o_s_tready);
        sb.accumulate_pixel(px);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_run(int unsigned count, pix_style_e style);
        for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(style));
        i_s_tvalid <= 1'b0;
        wait_drained();
    endtask

    // Growing the width below row 0 would read line store entries that were
    // never written. In that case close the frame first with a height of one.
    task automatic set_size(int unsigned w, int unsigned h);
        if (sb.row_pos != 0 && sb.effective(w, MAX_WIDTH) > sb.fill) begin
            write_reg(REG_IMAGE_HEIGHT, t_cfg'(1));
            while (sb.row_pos != 0) send_pixel(pick_pixel(PIX_ANY));
            i_s_tvalid <= 1'b0;
            wait_drained();
        end
        write_reg(REG_IMAGE_WIDTH, t_cfg'(w));
        write_reg(REG_IMAGE_HEIGHT, t_cfg'(h));
    endtask

    initial begin
        int unsigned idle_src[4];
        int unsigned idle_sink[4];
        int unsigned phase;
        int unsigned start_count;
        int unsigned w;
        int unsigned h;
        int unsigned count;
        pix_style_e  style;

        idle_src  = '{0, 45, 0, 14};
        idle_sink = '{0, 0, 45, 14};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Small frame with extreme pixel values.
        set_size(3, 2);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        i_s_tvalid <= 1'b0;
        wait_drained();

        // Zero sizes act as one: every pixel closes a frame.
        set_size(0, 0);
        send_run(2, PIX_EDGES);

        // Width shrinks mid-frame, so the current column ends its row.
        set_size(4, 3);
        send_run(6, PIX_ANY);
        set_size(2, 3);
        send_run(3, PIX_ANY);

        // Height shrinks below the current row, so the next row end closes the frame.
        set_size(1, 4095);
        send_run(3, PIX_ANY);
        set_size(1, 2);
        send_run(2, PIX_ANY);

        // Oversized width clamps to the largest row, so a long partial row must
        // not end early; near-full pixels keep the row sum climbing.
        src_idle_pct   = 14;
        sink_stall_pct = 14;
        set_size(4095, 3);
        send_run(300, PIX_BRIGHT);

        phase = 0;
        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_PIXELS) begin
            src_idle_pct   = idle_src[phase % 4];
            sink_stall_pct = idle_sink[phase % 4];
            count = $urandom_range(40, 160);
            case ($urandom_range(9))
                0: begin
                    w = $urandom_range(1);
                    h = $urandom_range(8);
                end
                1: begin
                    w = $urandom_range(2, 24);
                    case ($urandom_range(3))
                        0: h = 0;
                        1: h = 1;
                        2: h = 2048;
                        default: h = 4095;
                    endcase
                end
                2: begin
                    w = $urandom_range(1) ? 2048 : 4095;
                    h = $urandom_range(1, 4);
                    count = $urandom_range(20, 120);
                end
                3: begin
                    w = $urandom_range(4095);
                    h = $urandom_range(4095);
                end
                default: begin
                    w = $urandom_range(1, 32);
                    h = $urandom_range(1, 12);
                end
            endcase
            style = pix_style_e'($urandom_range(3));
            set_size(w, h);
            send_run(count, style);
            phase++;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (!sb.failed && sb.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
